[rtl/lcd_pkg.sv]
// Package: shared constants and controller/datapath interface types for the LRU chunk directory.
`timescale 1ns / 1ps
package lcd_pkg;

	localparam int DEF_WAYS = 8;
	localparam int CAP_W    = 4;
	localparam int CHUNK_W  = 16;
	localparam int WORD_W   = 32;
	localparam int SLOT_W   = 3;
	localparam int OUT_W    = 88;

	localparam logic MODE_LOOKUP = 1'b0;
	localparam logic MODE_INSERT = 1'b1;

	typedef struct packed {
		logic start;
		logic rd;
		logic cmp;
		logic upd;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic disabled;
		logic stop;
		logic out_free;
	} sts_t;

endpackage

[rtl/lcd_ctrl.sv]
// Controller: sequences the accept, way walk, update and result steps of one transaction.
`timescale 1ns / 1ps
module lcd_ctrl
	import lcd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_RD   = 5'b00010,
		ST_CMP  = 5'b00100,
		ST_UPD  = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t state_q, state_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.start = 1'b1;
					state_d   = sts.disabled ? ST_DONE : ST_RD;
				end
			end
			ST_RD: begin
				cmd.rd  = 1'b1;
				state_d = ST_CMP;
			end
			ST_CMP: begin
				cmd.cmp = 1'b1;
				state_d = sts.stop ? ST_UPD : ST_RD;
			end
			ST_UPD: begin
				cmd.upd = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/lcd_datapath.sv]
// Datapath: tag/stamp memories, valid bits, use clock, counters, walk registers, output register.
`timescale 1ns / 1ps
module lcd_datapath
	import lcd_pkg::*;
#(
	parameter int WAYS = DEF_WAYS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic [CAP_W-1:0]   cfg_data,
	input  logic [CHUNK_W-1:0] s_tdata,
	input  logic               s_tuser,
	input  logic               m_tready,
	output logic               m_tvalid,
	output logic [OUT_W-1:0]   m_tdata,
	input  cmd_t               cmd,
	output sts_t               sts
);

	localparam int IDX_W = (WAYS > 1) ? $clog2(WAYS) : 1;

	logic [CHUNK_W-1:0] tag_mem   [WAYS];
	logic [WORD_W-1:0]  stamp_mem [WAYS];

	logic [WAYS-1:0]    valid_q;
	logic [CAP_W-1:0]   cap_q;
	logic [WORD_W-1:0]  clock_q;
	logic [WORD_W-1:0]  hit_cnt_q;
	logic [WORD_W-1:0]  miss_cnt_q;

	logic               mode_q;
	logic [CHUNK_W-1:0] chunk_q;
	logic               dis_q;
	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   victim_q;
	logic               found_q;
	logic               ev_q;
	logic [WORD_W-1:0]  best_stamp_q;
	logic [CHUNK_W-1:0] best_tag_q;
	logic [CHUNK_W-1:0] rd_tag_q;
	logic [WORD_W-1:0]  rd_stamp_q;

	logic               m_tvalid_q;
	logic [OUT_W-1:0]   m_tdata_q;

	logic [CAP_W-1:0]   cap_new;
	logic               cur_valid;
	logic               match;
	logic               last_way;
	logic               stop;
	logic [WORD_W-1:0]  clock_inc;
	logic [SLOT_W-1:0]  slot_ext;
	logic               res_hit;
	logic               res_sv;
	logic               res_ev;
	logic [CHUNK_W-1:0] res_evc;

	assign cap_new   = (32'(cfg_data) > WAYS) ? CAP_W'(WAYS) : cfg_data;
	assign cur_valid = valid_q[idx_q];
	assign match     = cur_valid && (rd_tag_q == chunk_q);
	assign last_way  = (32'(idx_q) + 32'd1) == 32'(cap_q);
	assign stop      = last_way
		|| ((mode_q == MODE_LOOKUP) && match)
		|| ((mode_q == MODE_INSERT) && !cur_valid);
	assign clock_inc = clock_q + 32'd1;

	assign sts.disabled = (cap_q == '0);
	assign sts.stop     = stop;
	assign sts.out_free = !m_tvalid_q || m_tready;

	assign slot_ext = SLOT_W'(victim_q);
	assign res_hit  = !dis_q && (mode_q == MODE_LOOKUP) && found_q;
	assign res_sv   = !dis_q && ((mode_q == MODE_INSERT) || found_q);
	assign res_ev   = !dis_q && (mode_q == MODE_INSERT) && ev_q;
	assign res_evc  = res_ev ? best_tag_q : '0;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// memories: read during the walk, written at the update step
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_tag_q   <= tag_mem[idx_q];
			rd_stamp_q <= stamp_mem[idx_q];
		end
		if (cmd.upd && ((mode_q == MODE_INSERT) || found_q)) begin
			stamp_mem[victim_q] <= clock_inc;
			if (mode_q == MODE_INSERT) begin
				tag_mem[victim_q] <= chunk_q;
			end
		end
	end

	// item and walk registers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			mode_q  <= s_tuser;
			chunk_q <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dis_q        <= 1'b0;
			idx_q        <= '0;
			victim_q     <= '0;
			found_q      <= 1'b0;
			ev_q         <= 1'b0;
			best_stamp_q <= '0;
			best_tag_q   <= '0;
		end else if (cmd.start) begin
			dis_q    <= (cap_q == '0);
			idx_q    <= '0;
			victim_q <= '0;
			found_q  <= 1'b0;
			ev_q     <= 1'b0;
		end else if (cmd.cmp) begin
			if (!stop) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (mode_q == MODE_LOOKUP) begin
				if (match) begin
					found_q  <= 1'b1;
					victim_q <= idx_q;
				end
			end else if (!cur_valid) begin
				victim_q <= idx_q;
				ev_q     <= 1'b0;
			end else begin
				ev_q <= 1'b1;
				if ((idx_q == '0) || (rd_stamp_q < best_stamp_q)) begin
					best_stamp_q <= rd_stamp_q;
					best_tag_q   <= rd_tag_q;
					victim_q     <= idx_q;
				end
			end
		end
	end

	// capacity, valid bits, use clock and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q      <= '0;
			valid_q    <= '0;
			clock_q    <= 32'd1;
			hit_cnt_q  <= '0;
			miss_cnt_q <= '0;
		end else if (cfg_valid) begin
			if (cap_new != cap_q) begin
				cap_q   <= cap_new;
				valid_q <= '0;
				if (cap_new != '0) begin
					clock_q    <= 32'd1;
					hit_cnt_q  <= '0;
					miss_cnt_q <= '0;
				end
			end
		end else if (cmd.upd) begin
			if (mode_q == MODE_INSERT) begin
				valid_q[victim_q] <= 1'b1;
				clock_q           <= clock_inc;
			end else if (found_q) begin
				clock_q   <= clock_inc;
				hit_cnt_q <= hit_cnt_q + 32'd1;
			end else begin
				miss_cnt_q <= miss_cnt_q + 32'd1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			m_tdata_q <= {2'b00, miss_cnt_q, hit_cnt_q, res_evc, res_ev,
				(res_sv ? slot_ext : {SLOT_W{1'b0}}), res_sv, res_hit};
		end
	end

endmodule

[rtl/lru_chunk_cache_directory.sv]
// Top level: fully associative chunk tag directory with timestamp LRU replacement.
`timescale 1ns / 1ps
// Each transaction is a lookup (tuser 0) or an insert (tuser 1) of a chunk number and
// returns one result. The active entries are walked one at a time, each with a read step
// and then a compare step, through a single read port on the tag and stamp memories; a
// transaction visits at most active_ways entries, and with the cache disabled it skips the
// walk and the update. A lookup stops at the first valid match, an insert at the first free
// entry or after all active entries when it picks the oldest stamp. The result sits in an
// output register, so the next transaction is taken while it waits. Writing a new capacity
// clears all entries at once; the port is always ready.
module lru_chunk_cache_directory
	import lcd_pkg::*;
#(
	parameter int WAYS = DEF_WAYS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CAP_W-1:0]   cfg_data,    // active_ways
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [CHUNK_W-1:0] s_tdata,     // chunk_number
	input  logic               s_tuser,     // mode
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [OUT_W-1:0]   m_tdata      // hit, slot_valid, slot[3], evicted,
	                                        // evicted_chunk[16], hit_total[32],
	                                        // miss_total[32], zero pad[2]
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	lcd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lcd_datapath #(
		.WAYS (WAYS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
